### sv/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg: shared types and constants for the 8-bit instruction step core
// Payload structs, command and status codes, opcode constants, the ALU function.
// ----------------------------------------------------------------------------
package ebc_pkg;

    localparam int MemDepth = 65536;
    localparam int MemAw    = $clog2(MemDepth);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_SETPC = 2'd2;
    localparam logic [1:0] CMD_EXEC = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_UNIMP = 2'd2;

    localparam logic [7:0] OP_HLT  = 8'b01110110;
    localparam logic [7:0] OP_XCHG = 8'hEB;
    localparam logic [7:0] OP_LXIB = 8'h01;
    localparam logic [7:0] OP_LXID = 8'h11;
    localparam logic [7:0] OP_LXIH = 8'h21;
    localparam logic [7:0] OP_LXISP = 8'h31;
    localparam logic [7:0] OP_LHLD = 8'h2A;
    localparam logic [7:0] OP_SHLD = 8'h22;
    localparam logic [7:0] OP_LDA  = 8'h3A;
    localparam logic [7:0] OP_STA  = 8'h32;
    localparam logic [7:0] OP_LDAXB = 8'h0A;
    localparam logic [7:0] OP_LDAXD = 8'h1A;
    localparam logic [7:0] OP_STAXB = 8'h02;
    localparam logic [7:0] OP_STAXD = 8'h12;

    localparam logic [15:0] ROM_LIMIT_RESET = 16'd16382;

    localparam logic [2:0] RC_M = 3'd6;
    localparam logic [2:0] RC_A = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
    } ebc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc_out;
        logic [15:0] sp_out;
        logic [7:0]  acc_out;
        logic [7:0]  b_out;
        logic [7:0]  c_out;
        logic [7:0]  d_out;
        logic [7:0]  e_out;
        logic [7:0]  h_out;
        logic [7:0]  l_out;
        logic [7:0]  flags_out;
        logic [7:0]  read_data;
    } ebc_out_t;

    // ALU result: new accumulator and flag byte
    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flags;
    } ebc_alu_t;

    function automatic ebc_alu_t ebc_alu(input logic [1:0] kind, input logic [7:0] a,
                                         input logic [7:0] v, input logic cy_in);
        logic [7:0] b;
        logic       cin;
        logic [8:0] sum;
        logic [4:0] lo;
        logic       cy;
        ebc_alu_t   r;
        b   = kind[1] ? ~v : v;
        cin = kind[1] ? (kind[0] ? ~cy_in : 1'b1) : (kind[0] & cy_in);
        sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        cy  = sum[8] ^ kind[1];
        r.res = sum[7:0];
        r.flags = {sum[7], (sum[7:0] == 8'd0), 1'b0, lo[4], 1'b0, ~(^sum[7:0]), 1'b0, cy};
        return r;
    endfunction

endpackage

### sv/ebc_mem.sv
// ----------------------------------------------------------------------------
// ebc_mem: byte memory of the core
// One port, synchronous read: read data is registered and appears the cycle after the address.
// ----------------------------------------------------------------------------
module ebc_mem (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ebc_pkg::MemAw-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);
    import ebc_pkg::*;

    logic [7:0] mem_array [MemDepth];

    // write or read one byte per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        rdata <= mem_array[addr];
    end

endmodule

### sv/eight_bit_cpu_instruction_step.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_step: 8-bit accumulator core, one command per
// transaction
// Loads, reads, sets PC, or executes one instruction from internal memory.
// ----------------------------------------------------------------------------
// Each transaction is one command. All memory traffic goes through one
// single-port byte memory, one access per cycle with a registered read, so
// timing follows the number of accesses: load and set PC need none after
// acceptance, read needs one, and execute makes three opcode/operand fetches,
// then up to one operand read for M, LDA or LDAX, two for LHLD, or up to two
// writes for stores. One command is in flight at a time; the result waits in
// an output register and the next command is taken once it is consumed. Memory
// has no reset and is only defined where written; rom_limit guards instruction stores only.
module eight_bit_cpu_instruction_step (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  ebc_pkg::ebc_in_t       s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ebc_pkg::ebc_out_t      m_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [1:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import ebc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_F0    = 8'b00000010,
        S_F1    = 8'b00000100,
        S_F2    = 8'b00001000,
        S_DEC   = 8'b00010000,
        S_MRD   = 8'b00100000,
        S_MRD2  = 8'b01000000,
        S_WR2   = 8'b10000000
    } state_t;

    state_t      state_reg, state_next;
    ebc_in_t     cmd_reg, cmd_next;
    logic        out_valid_reg, out_valid_next;
    ebc_out_t    out_reg, out_next;
    logic [15:0] rom_limit_reg, rom_limit_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]  acc_reg, acc_next, flag_reg, flag_next;
    logic [7:0]  b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [7:0]  e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [7:0]  op_reg, op_next, lo_reg, lo_next;

    logic        mem_we;
    logic [15:0] mem_a;
    logic [7:0]  mem_wd, mem_rd;

    ebc_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_a[MemAw-1:0]),
        .wdata (mem_wd),
        .rdata (mem_rd)
    );

    // APB: single rom_limit register
    assign pready = 1'b1;
    always_comb begin
        prdata = (paddr == 2'd0) ? {16'd0, rom_limit_reg} : 32'd0;
        rom_limit_next = rom_limit_reg;
        if (psel && penable && pwrite && (paddr == 2'd0)) begin
            rom_limit_next = pwdata[15:0];
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    logic [15:0] hl, bc, de, w16;
    logic [7:0]  src_val, op_v;
    ebc_alu_t    alu_r;
    logic        done;
    logic [1:0]  st;
    logic [7:0]  rd_val;

    assign hl  = {h_reg, l_reg};
    assign bc  = {b_reg, c_reg};
    assign de  = {d_reg, e_reg};
    assign w16 = {mem_rd, lo_reg};

    function automatic logic [7:0] get_r(input logic [2:0] code, input logic [7:0] m,
                                         input logic [7:0] a, input logic [7:0] rb,
                                         input logic [7:0] rc, input logic [7:0] rd,
                                         input logic [7:0] re, input logic [7:0] rh,
                                         input logic [7:0] rl);
        logic [7:0] v;
        case (code)
            3'd0:    v = rb;
            3'd1:    v = rc;
            3'd2:    v = rd;
            3'd3:    v = re;
            3'd4:    v = rh;
            3'd5:    v = rl;
            RC_M:    v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    // main sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        pc_next = pc_reg; sp_next = sp_reg; acc_next = acc_reg; flag_next = flag_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; h_next = h_reg; l_next = l_reg;
        op_next = op_reg; lo_next = lo_reg;
        mem_we = 1'b0; mem_a = pc_reg; mem_wd = acc_reg;
        done = 1'b0; st = ST_DONE; rd_val = 8'd0;
        src_val = get_r(op_reg[2:0], mem_rd, acc_reg, b_reg, c_reg, d_reg, e_reg,
                        h_reg, l_reg);
        op_v = (state_reg == S_F2) ? lo_reg : src_val;
        alu_r = ebc_alu(op_reg[4:3], acc_reg, op_v, flag_reg[0]);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next = s_data;
                    mem_a = s_data.address;
                    case (s_data.cmd)
                        CMD_LOAD: begin
                            mem_we = 1'b1;
                            mem_wd = s_data.data;
                            done = 1'b1;
                        end
                        CMD_READ: state_next = S_MRD;
                        CMD_SETPC: begin
                            pc_next = s_data.address;
                            done = 1'b1;
                        end
                        default: begin
                            mem_a = pc_reg;
                            state_next = S_F0;
                        end
                    endcase
                end
            end
            S_F0: begin
                // opcode returns; request byte 2
                op_next = mem_rd;
                mem_a = pc_reg + 16'd1;
                state_next = S_F1;
            end
            S_F1: begin
                lo_next = mem_rd;
                mem_a = pc_reg + 16'd2;
                state_next = S_F2;
            end
            S_F2: begin
                // hi byte on mem_rd; decode
                state_next = S_IDLE;
                if (op_reg == OP_HLT) begin
                    done = 1'b1; st = ST_HALT;
                end else if (op_reg[7:6] == 2'b01) begin
                    if (op_reg[2:0] == RC_M) begin
                        mem_a = hl; state_next = S_DEC;
                    end else begin
                        state_next = S_DEC;
                    end
                end else if (op_reg[7:6] == 2'b10 && op_reg[5] == 1'b0) begin
                    mem_a = hl; state_next = S_DEC;
                end else if (op_reg[7:6] == 2'b00 && op_reg[2:0] == 3'b110) begin
                    state_next = S_DEC;
                end else if (op_reg[7:6] == 2'b11 && op_reg[2:0] == 3'b110
                             && op_reg[5] == 1'b0) begin
                    acc_next = alu_r.res; flag_next = alu_r.flags;
                    pc_next = pc_reg + 16'd2; done = 1'b1;
                end else begin
                    case (op_reg)
                        OP_LXIB: begin b_next = mem_rd; c_next = lo_reg;
                            pc_next = pc_reg + 16'd3; done = 1'b1; end
                        OP_LXID: begin d_next = mem_rd; e_next = lo_reg;
                            pc_next = pc_reg + 16'd3; done = 1'b1; end
                        OP_LXIH: begin h_next = mem_rd; l_next = lo_reg;
                            pc_next = pc_reg + 16'd3; done = 1'b1; end
                        OP_LXISP: begin sp_next = w16;
                            pc_next = pc_reg + 16'd3; done = 1'b1; end
                        OP_LDA: begin mem_a = w16; cmd_next.address = w16;
                            state_next = S_DEC; end
                        OP_LHLD: begin mem_a = w16; cmd_next.address = w16;
                            state_next = S_DEC; end
                        OP_STA: begin
                            mem_a = w16; mem_wd = acc_reg;
                            mem_we = (w16 > rom_limit_reg);
                            pc_next = pc_reg + 16'd3; done = 1'b1;
                        end
                        OP_SHLD: begin
                            mem_a = w16; mem_wd = l_reg;
                            mem_we = (w16 > rom_limit_reg);
                            cmd_next.address = w16 + 16'd1;
                            state_next = S_WR2;
                        end
                        OP_LDAXB: begin mem_a = bc; state_next = S_DEC; end
                        OP_LDAXD: begin mem_a = de; state_next = S_DEC; end
                        OP_STAXB: begin
                            mem_a = bc; mem_we = (bc > rom_limit_reg);
                            pc_next = pc_reg + 16'd1; done = 1'b1;
                        end
                        OP_STAXD: begin
                            mem_a = de; mem_we = (de > rom_limit_reg);
                            pc_next = pc_reg + 16'd1; done = 1'b1;
                        end
                        OP_XCHG: begin
                            h_next = d_reg; d_next = h_reg;
                            l_next = e_reg; e_next = l_reg;
                            pc_next = pc_reg + 16'd1; done = 1'b1;
                        end
                        default: begin done = 1'b1; st = ST_UNIMP; end
                    endcase
                end
            end
            S_DEC: begin
                // memory operand (if any) on mem_rd
                state_next = S_IDLE; done = 1'b1;
                if (op_reg[7:6] == 2'b01) begin
                    pc_next = pc_reg + 16'd1;
                    case (op_reg[5:3])
                        3'd0: b_next = src_val;
                        3'd1: c_next = src_val;
                        3'd2: d_next = src_val;
                        3'd3: e_next = src_val;
                        3'd4: h_next = src_val;
                        3'd5: l_next = src_val;
                        RC_M: begin
                            mem_a = hl; mem_wd = src_val;
                            mem_we = (hl > rom_limit_reg);
                        end
                        default: acc_next = src_val;
                    endcase
                end else if (op_reg[7:6] == 2'b10) begin
                    acc_next = alu_r.res; flag_next = alu_r.flags;
                    pc_next = pc_reg + 16'd1;
                end else if (op_reg[7:6] == 2'b00 && op_reg[2:0] == 3'b110) begin
                    pc_next = pc_reg + 16'd2;
                    case (op_reg[5:3])
                        3'd0: b_next = lo_reg;
                        3'd1: c_next = lo_reg;
                        3'd2: d_next = lo_reg;
                        3'd3: e_next = lo_reg;
                        3'd4: h_next = lo_reg;
                        3'd5: l_next = lo_reg;
                        RC_M: begin
                            mem_a = hl; mem_wd = lo_reg;
                            mem_we = (hl > rom_limit_reg);
                        end
                        default: acc_next = lo_reg;
                    endcase
                end else if (op_reg == OP_LHLD) begin
                    l_next = mem_rd;
                    mem_a = cmd_reg.address + 16'd1;
                    done = 1'b0; state_next = S_MRD2;
                end else if (op_reg == OP_LDA) begin
                    acc_next = mem_rd; pc_next = pc_reg + 16'd3;
                end else begin
                    acc_next = mem_rd; pc_next = pc_reg + 16'd1;
                end
            end
            S_MRD2: begin
                h_next = mem_rd; pc_next = pc_reg + 16'd3;
                done = 1'b1; state_next = S_IDLE;
            end
            S_WR2: begin
                mem_a = cmd_reg.address; mem_wd = h_reg;
                mem_we = (cmd_reg.address > rom_limit_reg);
                pc_next = pc_reg + 16'd3;
                done = 1'b1; state_next = S_IDLE;
            end
            S_MRD: begin
                rd_val = mem_rd; done = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // capture result
        if (done) begin
            out_valid_next = 1'b1;
            out_next = '{status: st, pc_out: pc_next, sp_out: sp_next,
                         acc_out: acc_next, b_out: b_next, c_out: c_next,
                         d_out: d_next, e_out: e_next, h_out: h_next,
                         l_out: l_next, flags_out: flag_next, read_data: rd_val};
        end
    end

    // control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            rom_limit_reg <= ROM_LIMIT_RESET;
            pc_reg <= '0; sp_reg <= '0; acc_reg <= '0; flag_reg <= '0;
            b_reg <= '0; c_reg <= '0; d_reg <= '0;
            e_reg <= '0; h_reg <= '0; l_reg <= '0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            rom_limit_reg <= rom_limit_next;
            pc_reg <= pc_next; sp_reg <= sp_next; acc_reg <= acc_next;
            flag_reg <= flag_next;
            b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            e_reg <= e_next; h_reg <= h_next; l_reg <= l_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
        op_reg <= op_next;
        lo_reg <= lo_next;
    end

endmodule
